[src/kaa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kaa_pkg
// Shared types and constants of the k-means assign/accumulate core.
// ----------------------------------------------------------------------------
package kaa_pkg;

  localparam int ModeW  = 2;
  localparam int IndexW = 6;
  localparam int CoordW = 16;
  localparam int DistW  = 34;
  localparam int SumW   = 48;
  localparam int CountW = 32;

  // Depth of the queue between front and back.
  localparam int QDepth = 4;
  localparam int QAddrW = 2;

  localparam logic [ModeW-1:0] MODE_LOAD   = 2'd0;
  localparam logic [ModeW-1:0] MODE_POINT  = 2'd1;
  localparam logic [ModeW-1:0] MODE_FINISH = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_POINT,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic [IndexW-1:0]         index;
    logic signed [CoordW-1:0]  x;
    logic signed [CoordW-1:0]  y;
    logic signed [CoordW-1:0]  z;
    logic signed [CoordW-1:0]  w;
  } item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic signed [CoordW-1:0] w;
  } centroid_t;

  typedef struct packed {
    logic signed [SumW-1:0] sum_x;
    logic signed [SumW-1:0] sum_y;
    logic signed [SumW-1:0] sum_z;
    logic signed [SumW-1:0] sum_w;
    logic [CountW-1:0]      count;
  } acc_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACC_RD,
    S_ACC_WR,
    S_DR_RD,
    S_DR_OUT
  } state_t;

endpackage

[src/kmeans_assign_accumulate_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_assign_accumulate_core
// Point-to-centroid assignment with per-cluster sums, counts and drain.
// ----------------------------------------------------------------------------
// Point: the scan reads one centroid per cycle through the distance pipeline,
//   then the accumulator is read and written and the result is registered;
//   the back takes no new request meanwhile. Load: written as it is popped.
// Finish: one summary per cluster, each an accumulator read, then output.
//   A stalled output holds the back end where it is.
// Reset clears the queue, control and accumulator valid bits; the centroid
//   store holds nothing defined until loaded. No clearing pass is needed.
module kmeans_assign_accumulate_core #(
  parameter int CLUSTERS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_mode,
  input  logic [5:0]          in_centroid_index,
  input  logic signed [15:0]  in_coord_x,
  input  logic signed [15:0]  in_coord_y,
  input  logic signed [15:0]  in_coord_z,
  input  logic signed [15:0]  in_coord_w,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_kind,
  output logic [5:0]          out_cluster,
  output logic [33:0]         out_distance,
  output logic signed [47:0]  out_sum_x,
  output logic signed [47:0]  out_sum_y,
  output logic signed [47:0]  out_sum_z,
  output logic signed [47:0]  out_sum_w,
  output logic [31:0]         out_point_count,
  output logic                out_last
);

  import kaa_pkg::*;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  item_t q_item;
  item_t q_head;

  kaa_front #(
    .CLUSTERS (CLUSTERS)
  ) u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_centroid_index (in_centroid_index),
    .in_coord_x        (in_coord_x),
    .in_coord_y        (in_coord_y),
    .in_coord_z        (in_coord_z),
    .in_coord_w        (in_coord_w),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_item            (q_item)
  );

  kaa_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  kaa_back #(
    .CLUSTERS (CLUSTERS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_cluster     (out_cluster),
    .out_distance    (out_distance),
    .out_sum_x       (out_sum_x),
    .out_sum_y       (out_sum_y),
    .out_sum_z       (out_sum_z),
    .out_sum_w       (out_sum_w),
    .out_point_count (out_point_count),
    .out_last        (out_last)
  );

endmodule

[src/kaa_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kaa_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kaa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/kaa_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kaa_front
// Accepts input requests, decodes the mode and drops requests that do nothing.
// ----------------------------------------------------------------------------
module kaa_front #(
  parameter int CLUSTERS = 16
) (
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_mode,
  input  logic [5:0]             in_centroid_index,
  input  logic signed [15:0]     in_coord_x,
  input  logic signed [15:0]     in_coord_y,
  input  logic signed [15:0]     in_coord_z,
  input  logic signed [15:0]     in_coord_w,
  input  logic                   q_full,
  output logic                   q_push,
  output kaa_pkg::item_t         q_item
);

  import kaa_pkg::*;

  logic keep;

  always_comb begin
    keep         = 1'b0;
    q_item.op    = OP_LOAD;
    q_item.index = in_centroid_index;
    q_item.x     = in_coord_x;
    q_item.y     = in_coord_y;
    q_item.z     = in_coord_z;
    q_item.w     = in_coord_w;
    case (in_mode)
      MODE_LOAD: begin
        // Loads to a slot past the cluster count are dropped here.
        keep = ({1'b0, in_centroid_index} < (IndexW + 1)'(CLUSTERS));
      end
      MODE_POINT: begin
        keep      = 1'b1;
        q_item.op = OP_POINT;
      end
      MODE_FINISH: begin
        keep      = 1'b1;
        q_item.op = OP_FINISH;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready && keep;

endmodule

[src/kaa_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kaa_fifo
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module kaa_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  kaa_pkg::item_t  push_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output kaa_pkg::item_t  head
);

  import kaa_pkg::*;

  item_t               items_r [QDepth];
  logic [QAddrW-1:0]   wr_ptr_r;
  logic [QAddrW-1:0]   rd_ptr_r;
  logic [QAddrW:0]     count_r;

  assign full  = (count_r == (QAddrW + 1)'(QDepth));
  assign empty = (count_r == '0);
  assign head  = items_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      items_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[src/kaa_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kaa_back
// Executes queued requests: centroid loads, nearest-centroid scans with
// accumulation, and the per-cluster drain. Holds the output register.
// ----------------------------------------------------------------------------
module kaa_back #(
  parameter int CLUSTERS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  kaa_pkg::item_t      q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_kind,
  output logic [5:0]          out_cluster,
  output logic [33:0]         out_distance,
  output logic signed [47:0]  out_sum_x,
  output logic signed [47:0]  out_sum_y,
  output logic signed [47:0]  out_sum_z,
  output logic signed [47:0]  out_sum_w,
  output logic [31:0]         out_point_count,
  output logic                out_last
);

  import kaa_pkg::*;

  localparam int IW = $clog2(CLUSTERS);
  localparam int AccW = $bits(acc_t);
  localparam int CenW = $bits(centroid_t);

  state_t state_r, state_nxt;

  item_t                    pt_r;
  logic [IW:0]              idx_r;
  logic                     v1_r, v2_r;
  logic [IW-1:0]            j1_r, j2_r;
  logic [DistW-1:0]         sq_r [4];
  logic [DistW-1:0]         best_r;
  logic [IW-1:0]            best_idx_r;
  logic [CLUSTERS-1:0]      acc_vld_r;
  logic                     out_valid_r;

  logic                     out_free;
  logic                     issue;
  logic                     scan_done;
  logic                     drain_end;

  // Control decoded from the state.
  logic                     cram_we;
  logic                     aram_re;
  logic                     aram_we;
  logic                     start_point;
  logic                     start_finish;
  logic                     emit_point;
  logic                     emit_sum;

  logic [CenW-1:0]          cram_rdata;
  centroid_t                cen;
  centroid_t                load_cen;
  logic [AccW-1:0]          aram_rdata;
  logic [IW-1:0]            aram_raddr;
  logic [IW-1:0]            acc_addr;
  acc_t                     acc_old;
  acc_t                     acc_new;
  logic signed [CoordW:0]   diff [4];
  logic signed [DistW-1:0]  sq [4];
  logic [DistW+1:0]         dsum;

  assign out_free  = !out_valid_r || out_ready;
  assign issue     = (state_r == S_SCAN) && (idx_r < (IW + 1)'(CLUSTERS));
  assign scan_done = (state_r == S_SCAN) && !issue && !v1_r && !v2_r;
  assign drain_end = (idx_r[IW-1:0] == IW'(CLUSTERS - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          case (q_head.op)
            OP_POINT:  state_nxt = S_SCAN;
            OP_FINISH: state_nxt = S_DR_RD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN:   if (scan_done) state_nxt = S_ACC_RD;
      S_ACC_RD: state_nxt = S_ACC_WR;
      S_ACC_WR: if (out_free) state_nxt = S_IDLE;
      S_DR_RD:  state_nxt = S_DR_OUT;
      S_DR_OUT: begin
        if (out_free) begin
          state_nxt = drain_end ? S_IDLE : S_DR_RD;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    cram_we      = 1'b0;
    aram_re      = 1'b0;
    aram_we      = 1'b0;
    start_point  = 1'b0;
    start_finish = 1'b0;
    emit_point   = 1'b0;
    emit_sum     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_head.op)
            OP_LOAD:   cram_we      = 1'b1;
            OP_POINT:  start_point  = 1'b1;
            OP_FINISH: start_finish = 1'b1;
            default:   cram_we      = 1'b0;
          endcase
        end
      end
      S_ACC_RD: aram_re = 1'b1;
      S_ACC_WR: begin
        aram_we    = out_free;
        emit_point = out_free;
      end
      S_DR_RD:  aram_re = 1'b1;
      S_DR_OUT: emit_sum = out_free;
      default:  q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Centroid store.
  assign load_cen.x = q_head.x;
  assign load_cen.y = q_head.y;
  assign load_cen.z = q_head.z;
  assign load_cen.w = q_head.w;

  kaa_ram #(
    .WIDTH (CenW),
    .DEPTH (CLUSTERS)
  ) u_cen_ram (
    .clk   (clk),
    .we    (cram_we),
    .waddr (q_head.index[IW-1:0]),
    .wdata (load_cen),
    .re    (issue),
    .raddr (idx_r[IW-1:0]),
    .rdata (cram_rdata)
  );

  assign cen = centroid_t'(cram_rdata);

  // Distance pipeline: read, square, then sum and compare.
  always_comb begin
    diff[0] = {pt_r.x[CoordW-1], pt_r.x} - {cen.x[CoordW-1], cen.x};
    diff[1] = {pt_r.y[CoordW-1], pt_r.y} - {cen.y[CoordW-1], cen.y};
    diff[2] = {pt_r.z[CoordW-1], pt_r.z} - {cen.z[CoordW-1], cen.z};
    diff[3] = {pt_r.w[CoordW-1], pt_r.w} - {cen.w[CoordW-1], cen.w};
    for (int k = 0; k < 4; k++) begin
      sq[k] = DistW'(diff[k] * diff[k]);
    end
  end

  assign dsum = {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]} + {2'b00, sq_r[3]};

  always_ff @(posedge clk) begin
    if (start_point) begin
      pt_r <= q_head;
    end
    if (start_point || start_finish) begin
      idx_r <= '0;
    end else if (issue || (emit_sum && !drain_end)) begin
      idx_r <= idx_r + 1'b1;
    end
    j1_r <= idx_r[IW-1:0];
    j2_r <= j1_r;
    if (v1_r) begin
      for (int k = 0; k < 4; k++) begin
        sq_r[k] <= unsigned'(sq[k]);
      end
    end
    // Strict less-than keeps the lower index on a tie.
    if (v2_r && ((j2_r == '0) || (dsum[DistW-1:0] < best_r))) begin
      best_r     <= dsum[DistW-1:0];
      best_idx_r <= j2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
    end
  end

  // Accumulator store; an entry whose valid bit is clear reads as zero.
  assign aram_raddr = (state_r == S_ACC_RD) ? best_idx_r : idx_r[IW-1:0];
  assign acc_addr   = (state_r == S_ACC_WR) ? best_idx_r : idx_r[IW-1:0];

  kaa_ram #(
    .WIDTH (AccW),
    .DEPTH (CLUSTERS)
  ) u_acc_ram (
    .clk   (clk),
    .we    (aram_we),
    .waddr (best_idx_r),
    .wdata (acc_new),
    .re    (aram_re),
    .raddr (aram_raddr),
    .rdata (aram_rdata)
  );

  assign acc_old = acc_vld_r[acc_addr] ? acc_t'(aram_rdata) : '0;

  always_comb begin
    acc_new.sum_x = acc_old.sum_x + SumW'(pt_r.x);
    acc_new.sum_y = acc_old.sum_y + SumW'(pt_r.y);
    acc_new.sum_z = acc_old.sum_z + SumW'(pt_r.z);
    acc_new.sum_w = acc_old.sum_w + SumW'(pt_r.w);
    acc_new.count = acc_old.count + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= '0;
    end else if (aram_we) begin
      acc_vld_r[best_idx_r] <= 1'b1;
    end else if (emit_sum) begin
      acc_vld_r[idx_r[IW-1:0]] <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_point || emit_sum) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_point) begin
      out_kind        <= 1'b0;
      out_cluster     <= IndexW'(best_idx_r);
      out_distance    <= best_r;
      out_sum_x       <= '0;
      out_sum_y       <= '0;
      out_sum_z       <= '0;
      out_sum_w       <= '0;
      out_point_count <= '0;
      out_last        <= 1'b0;
    end else if (emit_sum) begin
      out_kind        <= 1'b1;
      out_cluster     <= IndexW'(idx_r[IW-1:0]);
      out_distance    <= '0;
      out_sum_x       <= acc_old.sum_x;
      out_sum_y       <= acc_old.sum_y;
      out_sum_z       <= acc_old.sum_z;
      out_sum_w       <= acc_old.sum_w;
      out_point_count <= acc_old.count;
      out_last        <= drain_end;
    end
  end

  assign out_valid = out_valid_r;

endmodule
